FILE: src/tbvp_pkg.sv
// Shared types, constants and helper functions for the tilt box vertex projector.
// No dependencies.
package tbvp_pkg;

	localparam int CordicStages = 16;
	localparam int AngPi        = 25736;
	localparam int AngHalfPi    = 12868;
	localparam int InvGainQ14   = 9949;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_CENTER_X       = 3'd0;
	localparam logic [2:0] REG_CENTER_Y       = 3'd1;
	localparam logic [2:0] REG_SCALE          = 3'd2;
	localparam logic [2:0] REG_HALF_LENGTH    = 3'd3;
	localparam logic [2:0] REG_HALF_WIDTH     = 3'd4;
	localparam logic [2:0] REG_HALF_THICKNESS = 3'd5;

	// Vectoring datapath width: operands up to about 2^31 grow by the CORDIC gain
	localparam int VecW = 36;
	// Rotating datapath width: 9949*2^16 grows by the gain
	localparam int RotW = 32;
	localparam int AngW = 17;

	function automatic logic signed [AngW-1:0] atan_tab(input int i);
		case (i)
			0:  atan_tab = 17'sd6434;
			1:  atan_tab = 17'sd3798;
			2:  atan_tab = 17'sd2007;
			3:  atan_tab = 17'sd1019;
			4:  atan_tab = 17'sd511;
			5:  atan_tab = 17'sd256;
			6:  atan_tab = 17'sd128;
			7:  atan_tab = 17'sd64;
			8:  atan_tab = 17'sd32;
			9:  atan_tab = 17'sd16;
			10: atan_tab = 17'sd8;
			11: atan_tab = 17'sd4;
			12: atan_tab = 17'sd2;
			13: atan_tab = 17'sd1;
			default: atan_tab = 17'sd0;
		endcase
	endfunction

	typedef struct packed {
		logic [9:0]  center_x;
		logic [9:0]  center_y;
		logic [7:0]  scale;
		logic [14:0] half_length;
		logic [14:0] half_width;
		logic [14:0] half_thickness;
	} cfg_t;

	// Pitch/roll sin and cos, Q1.14
	typedef struct packed {
		logic signed [15:0] sp;
		logic signed [15:0] cp;
		logic signed [15:0] sr;
		logic signed [15:0] cr;
	} trig_t;

endpackage

FILE: src/tbvp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Standalone; carries a 48-bit tag alongside each radicand.
module tbvp_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [61:0]        radicand,
	input  logic [47:0]        tag_in,
	output logic               out_valid,
	output logic [30:0]        root,
	output logic [47:0]        tag_out
);
	// 31 root bits; one restoring step per stage
	localparam int N = 31;
	logic [63:0] rem_q  [N+1];
	logic [30:0] rt_q   [N+1];
	logic [47:0] tag_q  [N+1];
	logic        vld_q  [N+1];

	always_comb begin
		rem_q[0] = {2'b00, radicand};
		rt_q[0]  = '0;
		tag_q[0] = tag_in;
		vld_q[0] = in_valid;
	end

	for (genvar s = 0; s < N; s++) begin : g_st
		logic [63:0] rem_r;
		logic [30:0] rt_r;
		logic [47:0] tag_r;
		logic        vld_r;
		logic [33:0] trial;
		logic [33:0] part;
		always_comb begin
			part  = 34'(rem_q[s] >> (2*(N-1-s)));
			trial = {1'b0, rt_q[s], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_r <= 1'b0;
			end else if (en) begin
				vld_r <= vld_q[s];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				tag_r <= tag_q[s];
				if (part >= trial) begin
					rem_r <= rem_q[s] - (64'(trial) << (2*(N-1-s)));
					rt_r  <= {rt_q[s][29:0], 1'b1};
				end else begin
					rem_r <= rem_q[s];
					rt_r  <= {rt_q[s][29:0], 1'b0};
				end
			end
		end
		always_comb begin
			rem_q[s+1] = rem_r;
			rt_q[s+1]  = rt_r;
			tag_q[s+1] = tag_r;
			vld_q[s+1] = vld_r;
		end
	end

	assign out_valid = vld_q[N];
	assign root      = rt_q[N];
	assign tag_out   = tag_q[N];
endmodule

FILE: src/tbvp_vec_cordic.sv
// Pipelined vectoring CORDIC: atan2 of two operands, Q3.13 angle out.
// Depends on tbvp_pkg.
module tbvp_vec_cordic (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [tbvp_pkg::VecW-1:0]   xin,
	input  logic signed [tbvp_pkg::VecW-1:0]   yin,
	output logic signed [tbvp_pkg::AngW-1:0]   ang
);
	localparam int W  = tbvp_pkg::VecW;
	localparam int AW = tbvp_pkg::AngW;
	localparam int N  = tbvp_pkg::CordicStages;

	logic signed [W-1:0]  x_q [N+1];
	logic signed [W-1:0]  y_q [N+1];
	logic signed [AW-1:0] a_q [N+1];
	logic                 z_q [N+1];

	// Pre-rotate by pi when x is negative
	always_ff @(posedge clk) begin
		if (en) begin
			z_q[0] <= (xin == '0) && (yin == '0);
			if (xin < 0) begin
				x_q[0] <= -xin;
				y_q[0] <= -yin;
				a_q[0] <= (yin >= 0) ? AW'(tbvp_pkg::AngPi) : -AW'(tbvp_pkg::AngPi);
			end else begin
				x_q[0] <= xin;
				y_q[0] <= yin;
				a_q[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		always_ff @(posedge clk) begin
			if (en) begin
				z_q[i+1] <= z_q[i];
				if (y_q[i] > 0) begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					a_q[i+1] <= a_q[i] + tbvp_pkg::atan_tab(i);
				end else begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					a_q[i+1] <= a_q[i] - tbvp_pkg::atan_tab(i);
				end
			end
		end
	end

	// Clamp to +-pi; zero vector gives zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (z_q[N])
				ang <= '0;
			else if (a_q[N] > AW'(tbvp_pkg::AngPi))
				ang <= AW'(tbvp_pkg::AngPi);
			else if (a_q[N] < -AW'(tbvp_pkg::AngPi))
				ang <= -AW'(tbvp_pkg::AngPi);
			else
				ang <= a_q[N];
		end
	end
endmodule

FILE: src/tbvp_rot_cordic.sv
// Pipelined rotating CORDIC: sin and cos of a Q3.13 angle, Q1.14 out.
// Depends on tbvp_pkg.
module tbvp_rot_cordic (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [tbvp_pkg::AngW-1:0] ang,
	output logic signed [15:0]               sin_o,
	output logic signed [15:0]               cos_o
);
	localparam int W  = tbvp_pkg::RotW;
	localparam int AW = tbvp_pkg::AngW;
	localparam int N  = tbvp_pkg::CordicStages;

	logic signed [W-1:0]  x_q [N+1];
	logic signed [W-1:0]  y_q [N+1];
	logic signed [AW-1:0] a_q [N+1];
	logic                 n_q [N+1];
	logic signed [W-1:0]  xr, yr;
	logic signed [15:0]   cx, sy;

	// Fold into +-pi/2
	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= W'(tbvp_pkg::InvGainQ14 * 65536);
			y_q[0] <= '0;
			if (ang > AW'(tbvp_pkg::AngHalfPi)) begin
				a_q[0] <= ang - AW'(tbvp_pkg::AngPi);
				n_q[0] <= 1'b1;
			end else if (ang < -AW'(tbvp_pkg::AngHalfPi)) begin
				a_q[0] <= ang + AW'(tbvp_pkg::AngPi);
				n_q[0] <= 1'b1;
			end else begin
				a_q[0] <= ang;
				n_q[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		always_ff @(posedge clk) begin
			if (en) begin
				n_q[i+1] <= n_q[i];
				if (a_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					a_q[i+1] <= a_q[i] - tbvp_pkg::atan_tab(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					a_q[i+1] <= a_q[i] + tbvp_pkg::atan_tab(i);
				end
			end
		end
	end

	always_comb begin
		xr = (x_q[N] + W'(32768)) >>> 16;
		yr = (y_q[N] + W'(32768)) >>> 16;
		cx = n_q[N] ? -16'(xr) : 16'(xr);
		sy = n_q[N] ? -16'(yr) : 16'(yr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= (cx > 16'sd16384) ? 16'sd16384 : (cx < -16'sd16384 ? -16'sd16384 : cx);
			sin_o <= (sy > 16'sd16384) ? 16'sd16384 : (sy < -16'sd16384 ? -16'sd16384 : sy);
		end
	end
endmodule

FILE: src/tbvp_corner.sv
// Corner rotation and projection pipeline: one corner per cycle while en is high.
// Depends on tbvp_pkg.
module tbvp_corner (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2:0]            idx,
	input  tbvp_pkg::trig_t       trig,
	input  tbvp_pkg::cfg_t        cfg,
	output logic                  out_valid,
	output logic [2:0]            out_idx,
	output logic signed [11:0]    sx,
	output logic signed [11:0]    sy
);
	logic signed [15:0] x, y, z;
	// stage 1: first products
	logic signed [31:0] ycp_s1, zsp_s1, ysp_s1, zcp_s1, xcr_s1;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0]         i_s1, i_s2, i_s3, i_s4, i_s5;
	tbvp_pkg::trig_t    t_s1;
	// stage 2
	logic signed [32:0] y1_s2, z1_s2;
	logic signed [31:0] xcr_s2;
	logic signed [15:0] sr_s2;
	// stage 3
	logic signed [32:0] y1_s3;
	logic signed [48:0] z1sr_s3;
	logic signed [45:0] xcr_s3;
	// stages 4 and 5: x sum, then scale products
	logic signed [49:0] x2_s4;
	logic signed [32:0] y1_s4;
	logic signed [58:0] px_s5;
	logic signed [41:0] py_s5;
	logic signed [17:0] ox, oy;
	logic signed [18:0] tx, ty;

	always_comb begin
		x = (idx[0] ^ idx[1]) ? 16'(cfg.half_length) : -16'(cfg.half_length);
		y = idx[1] ? 16'(cfg.half_width) : -16'(cfg.half_width);
		z = idx[2] ? 16'(cfg.half_thickness) : -16'(cfg.half_thickness);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i_s1 <= idx; i_s2 <= i_s1; i_s3 <= i_s2; i_s4 <= i_s3; i_s5 <= i_s4;
			t_s1   <= trig;
			ycp_s1 <= y * trig.cp;
			zsp_s1 <= z * trig.sp;
			ysp_s1 <= y * trig.sp;
			zcp_s1 <= z * trig.cp;
			xcr_s1 <= x * trig.cr;
			y1_s2  <= 33'(ycp_s1) - 33'(zsp_s1);
			z1_s2  <= 33'(ysp_s1) + 33'(zcp_s1);
			xcr_s2 <= xcr_s1;
			sr_s2  <= t_s1.sr;
			y1_s3  <= y1_s2;
			z1sr_s3 <= z1_s2 * sr_s2;
			xcr_s3 <= 46'(xcr_s2) <<< 14;
			x2_s4  <= 50'(xcr_s3) + 50'(z1sr_s3);
			y1_s4  <= y1_s3;
			px_s5  <= x2_s4 * $signed({1'b0, cfg.scale});
			py_s5  <= y1_s4 * $signed({1'b0, cfg.scale});
		end
	end

	// Truncate toward zero: bias negatives before the shift
	always_comb begin
		ox = 18'((px_s5 + (px_s5 < 0 ? 59'sd4398046511103 : 59'sd0)) >>> 42);
		oy = 18'((py_s5 + (py_s5 < 0 ? 42'sd268435455 : 42'sd0)) >>> 28);
		tx = 19'(ox) + 19'($signed({1'b0, cfg.center_x}));
		ty = 19'(oy) + 19'($signed({1'b0, cfg.center_y}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_idx <= i_s5;
			sx <= (tx > 19'sd2047) ? 12'sd2047 : (tx < -19'sd2048 ? -12'sd2048 : 12'(tx));
			sy <= (ty > 19'sd2047) ? 12'sd2047 : (ty < -19'sd2048 ? -12'sd2048 : 12'(ty));
		end
	end
endmodule

FILE: src/tilt_box_vertex_projector.sv
// Tilt box vertex projector: accelerometer sample in, eight projected box corners out.
// Depends on tbvp_pkg, tbvp_isqrt, tbvp_vec_cordic, tbvp_rot_cordic, tbvp_corner.
//
// Usage:
//   s_axis carries one accelerometer sample per transaction (x, y, z, signed 16 bit).
//   m_axis carries eight transactions per sample, corners 0..7, tlast on corner 7.
//   Configuration writes (center, scale, box half sizes) go through cfg_we/cfg_idx/
//   cfg_wdata; issue them only while no sample is in flight.
// Admission: after each accepted sample s_axis_tready stays low while the gap counter
//   wraps, so the corner sequencer finishes one run of eight corners, one per advancing
//   cycle, before the next sample's angles arrive.
// Pipeline: 31 square root stages, 18 vectoring CORDIC stages, 18 rotating CORDIC
//   stages, 6 corner stages and the output register lie between a sample and its
//   first corner; the other corners follow in index order.
// Stall: the whole pipeline advances only when the output register is empty or being
//   taken; while a corner waits for m_axis_tready every stage holds, nothing is lost.
// Reset: arst_n clears all valid bits and restores the register reset values.
module tilt_box_vertex_projector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // corner_index[2:0], screen_x[14:3], screen_y[26:15], 0
	output logic        m_axis_tlast,  // last_corner
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [14:0] cfg_wdata
);
	localparam int CL = 2 * tbvp_pkg::CordicStages + 4; // combined CORDIC latency

	tbvp_pkg::cfg_t  cfg_q;
	tbvp_pkg::trig_t trig;
	logic            en;
	logic            out_vld_q;
	logic [2:0]      out_idx_q;
	logic [11:0]     out_sx_q, out_sy_q;

	// Corner sequencer
	logic            seq_busy_q;
	logic [2:0]      seq_idx_q;
	tbvp_pkg::trig_t seq_trig_q;
	logic            in_acc;

	// Front end wiring
	logic signed [15:0] ay, az;
	logic [31:0]        sq;
	logic               sqrt_v;
	logic [30:0]        mag;
	logic [47:0]        tag;
	logic signed [tbvp_pkg::AngW-1:0] pitch, roll;
	logic               cv [CL+1];
	logic               trig_v;
	logic               c_v;
	logic [2:0]         c_idx;
	logic signed [11:0] c_sx, c_sy;

	// Advance everything when the output register can take a new corner
	assign en = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{center_x: 10'd100, center_y: 10'd100, scale: 8'd70,
				half_length: 15'd16384, half_width: 15'd12111, half_thickness: 15'd5699};
		end else if (cfg_we) begin
			case (cfg_idx)
				tbvp_pkg::REG_CENTER_X:       cfg_q.center_x       <= cfg_wdata[9:0];
				tbvp_pkg::REG_CENTER_Y:       cfg_q.center_y       <= cfg_wdata[9:0];
				tbvp_pkg::REG_SCALE:          cfg_q.scale          <= cfg_wdata[7:0];
				tbvp_pkg::REG_HALF_LENGTH:    cfg_q.half_length    <= cfg_wdata;
				tbvp_pkg::REG_HALF_WIDTH:     cfg_q.half_width     <= cfg_wdata;
				tbvp_pkg::REG_HALF_THICKNESS: cfg_q.half_thickness <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Space admissions with a wrapping gap counter so that each corner run
	// ends before the next sample's angles reach the sequencer.
	logic [2:0] gap_q;
	assign s_axis_tready = en && (gap_q == 3'd0);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (en) begin
			if (in_acc || gap_q != 3'd0)
				gap_q <= gap_q + 3'd1;
		end
	end

	always_comb begin
		ay = s_axis_tdata[31:16];
		az = s_axis_tdata[47:32];
		sq = 32'(ay * ay) + 32'(az * az);
	end

	tbvp_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_acc),
		.radicand({sq, 30'd0} >> 2), // sq << 28 within 62 bits
		.tag_in(s_axis_tdata), .out_valid(sqrt_v), .root(mag), .tag_out(tag)
	);

	tbvp_vec_cordic u_pitch (
		.clk(clk), .en(en),
		.xin(tbvp_pkg::VecW'($signed({1'b0, mag}))),
		.yin(-(tbvp_pkg::VecW'($signed(tag[15:0])) <<< 14)),
		.ang(pitch)
	);

	tbvp_vec_cordic u_roll (
		.clk(clk), .en(en),
		.xin(tbvp_pkg::VecW'($signed(tag[47:32])) <<< 14),
		.yin(tbvp_pkg::VecW'($signed(tag[31:16])) <<< 14),
		.ang(roll)
	);

	tbvp_rot_cordic u_sc_p (
		.clk(clk), .en(en), .ang(pitch), .sin_o(trig.sp), .cos_o(trig.cp)
	);

	tbvp_rot_cordic u_sc_r (
		.clk(clk), .en(en), .ang(roll), .sin_o(trig.sr), .cos_o(trig.cr)
	);

	// Valid bits travel alongside both CORDIC chains
	assign cv[0] = sqrt_v;
	for (genvar k = 0; k < CL; k++) begin : g_cv
		logic v_r;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_r <= 1'b0;
			else if (en) v_r <= cv[k];
		end
		assign cv[k+1] = v_r;
	end
	assign trig_v = cv[CL];

	// Expand each sample into eight corners
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_busy_q <= 1'b0;
			seq_idx_q  <= '0;
		end else if (en) begin
			if (trig_v) begin
				seq_busy_q <= 1'b1;
				seq_idx_q  <= 3'd1;
			end else if (seq_busy_q) begin
				seq_idx_q  <= seq_idx_q + 3'd1;
				seq_busy_q <= (seq_idx_q != 3'd7);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && trig_v) seq_trig_q <= trig;
	end

	tbvp_corner u_corner (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(trig_v || seq_busy_q),
		.idx(trig_v ? 3'd0 : seq_idx_q),
		.trig(trig_v ? trig : seq_trig_q),
		.cfg(cfg_q),
		.out_valid(c_v), .out_idx(c_idx), .sx(c_sx), .sy(c_sy)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= c_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_idx_q <= c_idx;
			out_sx_q  <= c_sx;
			out_sy_q  <= c_sy;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, out_sy_q, out_sx_q, out_idx_q};
	assign m_axis_tlast  = (out_idx_q == 3'd7);

	// Sample admission spacing matches the eight-corner expansion
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("sample admitted inside eight-cycle slot");

	// A new trig result never lands while a corner run is mid-way
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && trig_v) |-> !seq_busy_q)
		else $error("corner runs overlap");

	// Held output stays put under backpressure
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata) && m_axis_tvalid)
		else $error("stalled result changed");
endmodule
